>>> rtl/core/sdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdlp_pkg
// Types and constants for the signed decimal list packet parser.
// ----------------------------------------------------------------------------
package sdlp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BUSY = 2'd1,
    PH_DONE = 2'd2
  } sdlp_phase_e;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } sdlp_op_e;

  localparam logic [7:0] CH_START = 8'h73;  // s
  localparam logic [7:0] CH_END   = 8'h65;  // e
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ,
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_ZERO  = 8'h30;  // 0
  localparam logic [7:0] CH_NINE  = 8'h39;  // 9

  localparam logic [3:0] FIELD_CAP = 4'd15;

  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic               value_valid;
    logic [3:0]         value_index;
    logic signed [15:0] value;
    logic               packet_done;
    logic               aborted;
    logic [3:0]         value_count;
    logic [1:0]         parser_phase;
  } sdlp_result_t;

endpackage

>>> rtl/core/sdlp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdlp_core
// Parser state registers and the per-item update, one item per enabled cycle.
// ----------------------------------------------------------------------------
module sdlp_core
  import sdlp_pkg::*;
#(
  parameter int unsigned MAX_VALUES = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         op_i,
  input  logic [7:0]   rx_byte_i,
  output sdlp_result_t result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_VALUES + 1);
  localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_VALUES);

  sdlp_phase_e      phase_q, phase_d;
  logic [IDX_W-1:0] field_index_q, field_index_d;
  logic [3:0]       digit_count_q, digit_count_d;
  logic [15:0]      acc_q, acc_d;
  logic             minus_q, minus_d;
  logic [IDX_W-1:0] reported_q, reported_d;

  logic             v_valid;
  logic             done;
  logic             abort_flag;
  logic [15:0]      field_val;
  logic [3:0]       digit;
  logic [15:0]      acc_next;
  logic [IDX_W+3:0] idx_ext;
  logic [IDX_W+3:0] cnt_ext;

  assign field_val = minus_q ? (~acc_q + 16'd1) : acc_q;
  assign digit     = 4'(rx_byte_i - CH_ZERO);
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + {12'd0, digit};

  always_comb begin
    phase_d       = phase_q;
    field_index_d = field_index_q;
    digit_count_d = digit_count_q;
    acc_d         = acc_q;
    minus_d       = minus_q;
    reported_d    = reported_q;
    v_valid       = 1'b0;
    done          = 1'b0;
    abort_flag    = 1'b0;
    if (op_i == OP_RELEASE) begin
      if (phase_q == PH_DONE) begin
        phase_d = PH_IDLE;
      end
    end else begin
      case (phase_q)
        PH_IDLE, PH_DONE: begin
          if (rx_byte_i == CH_START) begin
            phase_d       = PH_BUSY;
            field_index_d = '0;
            digit_count_d = '0;
            acc_d         = '0;
            minus_d       = 1'b0;
            if (phase_q == PH_DONE) begin
              reported_d = '0;
            end
          end
        end
        PH_BUSY: begin
          if (rx_byte_i == CH_END || rx_byte_i == CH_COMMA) begin
            if (digit_count_q != 4'd0 && field_index_q < MaxIdx) begin
              v_valid = 1'b1;
              if (rx_byte_i == CH_END) begin
                reported_d = field_index_q + 1'b1;
              end else begin
                field_index_d = field_index_q + 1'b1;
              end
            end
            digit_count_d = '0;
            acc_d         = '0;
            minus_d       = 1'b0;
            if (rx_byte_i == CH_END) begin
              phase_d = PH_DONE;
              done    = 1'b1;
            end
          end else if (rx_byte_i inside {[CH_ZERO:CH_NINE]} || rx_byte_i == CH_MINUS) begin
            if (digit_count_q >= FIELD_CAP ||
                (rx_byte_i == CH_MINUS && digit_count_q != 4'd0)) begin
              phase_d    = PH_IDLE;
              abort_flag = 1'b1;
            end else begin
              if (rx_byte_i == CH_MINUS) begin
                minus_d = 1'b1;
              end else begin
                acc_d = acc_next;
              end
              digit_count_d = digit_count_q + 4'd1;
            end
          end else begin
            phase_d    = PH_IDLE;
            abort_flag = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign idx_ext = {4'd0, field_index_q};
  assign cnt_ext = {4'd0, reported_d};

  always_comb begin
    result_o.value_valid  = v_valid;
    result_o.value_index  = v_valid ? idx_ext[3:0] : 4'd0;
    result_o.value        = v_valid ? field_val : 16'sd0;
    result_o.packet_done  = done;
    result_o.aborted      = abort_flag;
    result_o.value_count  = cnt_ext[3:0];
    result_o.parser_phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      field_index_q <= '0;
      digit_count_q <= '0;
      acc_q         <= '0;
      minus_q       <= 1'b0;
      reported_q    <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      field_index_q <= field_index_d;
      digit_count_q <= digit_count_d;
      acc_q         <= acc_d;
      minus_q       <= minus_d;
      reported_q    <= reported_d;
    end
  end

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_index_q <= MaxIdx && reported_q <= MaxIdx)
    else $error("field index beyond capacity");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PH_DONE)
    else $error("terminator did not finish packet");

  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && abort_flag |=> phase_q == PH_IDLE && $stable(reported_q))
    else $error("abort did not return to idle");

  a_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_valid |-> !abort_flag && phase_q == PH_BUSY && field_index_q < MaxIdx)
    else $error("value emitted outside a packet");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(acc_q) && $stable(digit_count_q))
    else $error("state moved without an item");

endmodule

>>> rtl/core/signed_decimal_list_packet_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_list_packet_parser_unit
// Parses s<int>{,<int>}e packets byte by byte, one result item per input item.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                         tuser
//  s_axis    in   rx_byte[7:0]                  op
//  m_axis    out  result fields, 29 of 32 bits  -
//
//  one item per cycle sustained while m_axis accepts results; the path is
//  input register -> parser update -> result register
//  rst_ni clears control and parser state, asynchronously
//  a stalled m_axis holds the result; s_axis keeps accepting while the
//  input register can drain
// ----------------------------------------------------------------------------
module signed_decimal_list_packet_parser_unit
  import sdlp_pkg::*;
#(
  parameter int unsigned MAX_VALUES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // rx_byte
  input  logic                  s_axis_tuser,   // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // value_valid, value_index[3:0], value[15:0], packet_done, aborted,
  // value_count[3:0], parser_phase[1:0], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic                  in_valid_q;
  logic                  in_op_q;
  logic [7:0]            in_byte_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  adv;
  sdlp_result_t          res;
  logic [OUT_DATA_W-1:0] res_packed;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  sdlp_core #(
    .MAX_VALUES(MAX_VALUES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .op_i     (in_op_q),
    .rx_byte_i(in_byte_q),
    .result_o (res)
  );

  assign res_packed = {3'd0, res.parser_phase, res.value_count, res.aborted,
                       res.packet_done, res.value, res.value_index, res.value_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (adv) begin
      out_data_q <= res_packed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> bench/tb_signed_decimal_list_packet_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_list_packet_parser_unit
// Drives byte and release items into the packet parser and checks every result
// item against a cycle-free parser model kept in the bench. Directed items hit
// the edge cases; random packets, mostly well formed, with corrupt fields,
// noise and bursty traffic on both sides, cover the rest.
// ----------------------------------------------------------------------------
module tb_signed_decimal_list_packet_parser_unit;
  import sdlp_pkg::*;

  localparam int unsigned MAX_VALUES  = 10;
  localparam int          ITEMS_TOTAL = 1650;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          MAX_SHOWN   = 10;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // rx_byte
  logic                  s_axis_tuser  = 1'b0; // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // value_valid, value_index[3:0], value[15:0], packet_done, aborted,
  // value_count[3:0], parser_phase[1:0], zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  signed_decimal_list_packet_parser_unit #(
    .MAX_VALUES(MAX_VALUES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // parser model state
  sdlp_phase_e   mdl_phase   = PH_IDLE;
  int            mdl_field   = 0;
  int            mdl_chars   = 0;
  logic [15:0]   mdl_acc     = '0;
  logic          mdl_neg     = 1'b0;
  int            mdl_reported = 0;

  sdlp_result_t  parse_q[$];

  int items_sent   = 0;
  int burst_left   = 0;
  int burst_max    = 8;
  int gap_max      = 4;
  int ready_pct    = 70;
  int hold_request = 0;
  int hold_left    = 0;
  int cycles       = 0;
  int errors       = 0;
  int mismatches   = 0;
  int n_results    = 0;
  int n_values     = 0;
  int n_done       = 0;
  int n_aborts     = 0;

  function automatic void open_packet();
    mdl_phase = PH_BUSY;
    mdl_field = 0;
    mdl_chars = 0;
    mdl_acc   = '0;
    mdl_neg   = 1'b0;
  endfunction

  function automatic sdlp_result_t parse_step(input sdlp_op_e op, input logic [7:0] b);
    sdlp_result_t r;
    r = '0;
    if (op == OP_RELEASE) begin
      if (mdl_phase == PH_DONE) mdl_phase = PH_IDLE;
    end else begin
      case (mdl_phase)
        PH_IDLE: begin
          if (b == CH_START) open_packet();
        end
        PH_DONE: begin
          if (b == CH_START) begin
            open_packet();
            mdl_reported = 0;
          end
        end
        PH_BUSY: begin
          if (b == CH_END || b == CH_COMMA) begin
            if (mdl_chars > 0 && mdl_field < MAX_VALUES) begin
              r.value_valid = 1'b1;
              r.value_index = 4'(mdl_field);
              r.value       = mdl_neg ? 16'd0 - mdl_acc : mdl_acc;
              if (b == CH_END) mdl_reported = mdl_field + 1;
              else mdl_field++;
            end
            mdl_chars = 0;
            mdl_acc   = '0;
            mdl_neg   = 1'b0;
            if (b == CH_END) begin
              mdl_phase     = PH_DONE;
              r.packet_done = 1'b1;
            end
          end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS) begin
            if (mdl_chars >= FIELD_CAP || (b == CH_MINUS && mdl_chars != 0)) begin
              mdl_phase = PH_IDLE;
              r.aborted = 1'b1;
            end else begin
              if (b == CH_MINUS) mdl_neg = 1'b1;
              else mdl_acc = mdl_acc * 16'd10 + {8'd0, b - CH_ZERO};
              mdl_chars++;
            end
          end else begin
            mdl_phase = PH_IDLE;
            r.aborted = 1'b1;
          end
        end
        default: mdl_phase = PH_IDLE;
      endcase
    end
    r.value_count  = 4'(mdl_reported);
    r.parser_phase = mdl_phase;
    return r;
  endfunction

  // receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sdlp_result_t got;
    sdlp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value_valid  = m_axis_tdata[0];
      got.value_index  = m_axis_tdata[4:1];
      got.value        = m_axis_tdata[20:5];
      got.packet_done  = m_axis_tdata[21];
      got.aborted      = m_axis_tdata[22];
      got.value_count  = m_axis_tdata[26:23];
      got.parser_phase = m_axis_tdata[28:27];
      if (parse_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result item %0d", n_results);
      end else begin
        want = parse_q.pop_front();
        n_values += want.value_valid;
        n_done   += want.packet_done;
        n_aborts += want.aborted;
        if (got.value_valid !== want.value_valid || got.value_index !== want.value_index ||
            got.value !== want.value || got.packet_done !== want.packet_done ||
            got.aborted !== want.aborted || got.value_count !== want.value_count ||
            got.parser_phase !== want.parser_phase) begin
          errors++;
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("item %0d exp: vld=%0b idx=%0d val=%0d done=%0b abort=%0b cnt=%0d ph=%0d",
                     n_results, want.value_valid, want.value_index, want.value,
                     want.packet_done, want.aborted, want.value_count, want.parser_phase);
            $display("item %0d got: vld=%0b idx=%0d val=%0d done=%0b abort=%0b cnt=%0d ph=%0d",
                     n_results, got.value_valid, got.value_index, got.value,
                     got.packet_done, got.aborted, got.value_count, got.parser_phase);
          end
        end
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, parse_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called right after a rising edge; returns at the edge of acceptance
  task automatic send_item(input sdlp_op_e op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_q.push_back(parse_step(op, b));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (parse_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // one field: empty, lone minus, short, long, or too long
  task automatic send_field();
    int pick;
    int n;
    pick = $urandom_range(0, 19);
    if (pick == 0) return;
    if (pick == 1) begin
      send_byte(CH_MINUS);
      return;
    end
    if (pick < 15) n = $urandom_range(1, 5);
    else if (pick < 19) n = $urandom_range(6, 14);
    else n = $urandom_range(14, 16);
    if ($urandom_range(0, 9) < 3) send_byte(CH_MINUS);
    send_digits(n);
  endtask

  task automatic send_corruption();
    case ($urandom_range(0, 3))
      0: send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_digits($urandom_range(0, 3));
        send_byte(CH_MINUS);
      end
      2: send_digits(16);
      default: begin
        send_byte(CH_MINUS);
        send_byte(CH_MINUS);
      end
    endcase
  endtask

  task automatic send_random_packet();
    int pick;
    int fields;
    pick = $urandom_range(0, 9);
    if (pick < 6) fields = $urandom_range(0, 4);
    else if (pick < 8) fields = $urandom_range(5, 9);
    else fields = $urandom_range(10, 12);
    send_byte(CH_START);
    for (int i = 0; i < fields; i++) begin
      if (i > 0) send_byte(CH_COMMA);
      if ($urandom_range(0, 99) < 4) send_corruption();
      send_field();
    end
    send_byte(CH_END);
    pick = $urandom_range(0, 19);
    if (pick < 10) send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    else if (pick < 13) send_byte(8'($urandom_range(0, 255)));
    else if (pick < 15) begin
      send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
      send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      send_item(sdlp_op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    // two fields, empty field, lone minus, wrap to -1, then done
    send_byte(CH_START);
    send_byte("1");
    send_byte("2");
    send_byte(CH_COMMA);
    send_byte(CH_MINUS);
    send_byte("3");
    send_byte(CH_COMMA);
    send_byte(CH_COMMA);
    send_byte(CH_MINUS);
    send_byte(CH_COMMA);
    send_digits(0);
    send_byte("6");
    send_byte("5");
    send_byte("5");
    send_byte("3");
    send_byte("5");
    send_byte(CH_END);
    send_item(OP_RELEASE, 8'hFF);
    send_item(OP_RELEASE, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    // misplaced minus, foreign bytes
    send_byte(CH_START);
    send_byte("7");
    send_byte(CH_MINUS);
    send_byte(CH_START);
    send_byte(8'hFF);
    send_byte(CH_START);
    send_byte(8'h00);
    // empty last field leaves count stale, restart from done
    send_byte(CH_START);
    send_byte(CH_END);
    send_byte(CH_START);
    send_byte(CH_END);
  endtask

  task automatic test_random_packets(input int quota, input int gaps, input int ready);
    gap_max   = gaps;
    ready_pct = ready;
    while (items_sent < quota) begin
      send_random_packet();
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
    end
    wait_all_results();
  endtask

  task automatic test_output_hold_off();
    gap_max      = 0;
    ready_pct    = 100;
    hold_request = 300;
    for (int i = 0; i < 6; i++) send_random_packet();
    wait_all_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_all_results();
    test_random_packets(ITEMS_TOTAL * 1 / 5, 0, 100);
    test_random_packets(ITEMS_TOTAL * 2 / 5, 6, 50);
    test_output_hold_off();
    test_random_packets(ITEMS_TOTAL * 3 / 5, 2, 90);
    test_random_packets(ITEMS_TOTAL * 4 / 5, 10, 30);
    test_random_packets(ITEMS_TOTAL, 3, 75);

    repeat (20) @(posedge clk_i);
    if (parse_q.size() != 0) errors++;
    $display("sent %0d items, checked %0d results", items_sent, n_results);
    $display("values %0d, packets finished %0d, aborts %0d, mismatches %0d",
             n_values, n_done, n_aborts, mismatches);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
